@@ hdl/rci_pkg.sv @@
// shared widths, side-band type and saturation helper for the ray/circle core
// no dependencies; every other file of the core imports this package
package rci_pkg;

  localparam int POS_W         = 24;
  localparam int DIR_W         = 16;
  localparam int RAD_W         = 23;
  localparam int T_W           = 26;
  localparam int DIR_FRAC_BITS = 14;

  localparam int OC_W   = POS_W + 1;
  localparam int PROD_W = OC_W + DIR_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int B_W    = DOT_W + 1 - DIR_FRAC_BITS;
  localparam int NB_W   = B_W + 1;
  localparam int SQ_W   = 2 * OC_W;
  localparam int RR_W   = 2 * RAD_W;
  localparam int C_W    = SQ_W + 1;
  localparam int BB_W   = 2 * B_W;
  localparam int HS_W   = BB_W + 1;
  localparam int ROOT_W = 27;
  localparam int SQR_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SUM_W  = NB_W + 1;
  localparam int RND    = 1 << (DIR_FRAC_BITS - 1);

  localparam int IN_W  = 152;
  localparam int OUT_W = 56;

  // travels beside the radicand through the square root stages
  typedef struct packed {
    logic                   valid;
    logic                   miss;
    logic signed [NB_W-1:0] nb;
  } rci_side_t;

  function automatic logic signed [T_W-1:0] sat_t(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-T_W:0] top;
    top = v[SUM_W-1:T_W-1];
    if (top == '0 || top == '1) begin
      sat_t = v[T_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_t = {1'b1, {(T_W-1){1'b0}}};
    end else begin
      sat_t = {1'b0, {(T_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ hdl/rci_front.sv @@
// front stages: offset, products, rounded dot, discriminant h
// depends on rci_pkg; six registered stages, all held while en is low
module rci_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [rci_pkg::POS_W-1:0] origin_x,
  input  logic signed [rci_pkg::POS_W-1:0] origin_y,
  input  logic signed [rci_pkg::DIR_W-1:0] dir_x,
  input  logic signed [rci_pkg::DIR_W-1:0] dir_y,
  input  logic signed [rci_pkg::POS_W-1:0] center_x,
  input  logic signed [rci_pkg::POS_W-1:0] center_y,
  input  logic        [rci_pkg::RAD_W-1:0] radius,
  output logic        [rci_pkg::SQR_W-1:0] rad,
  output rci_pkg::rci_side_t               side
);
  import rci_pkg::*;

  logic [5:1] v;

  // stage 1
  logic signed [OC_W-1:0]  ocx, ocy;
  logic signed [DIR_W-1:0] dx, dy;
  logic        [RAD_W-1:0] r1;
  // stage 2
  logic signed [PROD_W-1:0] px, py;
  logic signed [SQ_W-1:0]   sx, sy;
  logic        [RR_W-1:0]   rr;
  // stage 3
  logic signed [DOT_W-1:0] dot;
  logic signed [C_W-1:0]   c3;
  // stage 4
  logic signed [B_W-1:0] b;
  logic signed [C_W-1:0] c4;
  // stage 5
  logic signed [BB_W-1:0] bb;
  logic signed [NB_W-1:0] nb5;
  logic signed [C_W-1:0]  c5;

  logic signed [DOT_W:0]   dot_rnd;
  logic signed [HS_W-1:0]  hs;

  assign dot_rnd = (DOT_W+1)'(dot) + (DOT_W+1)'(RND);
  assign hs      = HS_W'(bb) - HS_W'(c5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      side.valid <= 1'b0;
    end else if (en) begin
      v          <= {v[4:1], in_valid};
      side.valid <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ocx <= OC_W'(origin_x) - OC_W'(center_x);
      ocy <= OC_W'(origin_y) - OC_W'(center_y);
      dx  <= dir_x;
      dy  <= dir_y;
      r1  <= radius;

      px <= ocx * dx;
      py <= ocy * dy;
      sx <= ocx * ocx;
      sy <= ocy * ocy;
      rr <= r1 * r1;

      dot <= DOT_W'(px) + DOT_W'(py);
      c3  <= C_W'(sx) + C_W'(sy) - C_W'(rr);

      // round half up to the coordinate scale
      b  <= dot_rnd[DOT_W:DIR_FRAC_BITS];
      c4 <= c3;

      bb  <= b * b;
      nb5 <= -NB_W'(b);
      c5  <= c4;

      side.miss <= hs[HS_W-1];
      side.nb   <= nb5;
      rad       <= hs[HS_W-1] ? '0 : hs[SQR_W-1:0];
    end
  end

endmodule

@@ hdl/rci_isqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on rci_pkg; ROOT_W registered stages, held while en is low
module rci_isqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic        [rci_pkg::SQR_W-1:0]  rad_in,
  input  rci_pkg::rci_side_t                side_in,
  output logic        [rci_pkg::ROOT_W-1:0] root,
  output rci_pkg::rci_side_t                side_out
);
  import rci_pkg::*;

  logic      [SQR_W-1:0]  rad_s  [1:ROOT_W];
  logic      [REM_W-1:0]  rem_s  [1:ROOT_W];
  logic      [ROOT_W-1:0] root_s [1:ROOT_W];
  rci_side_t              side_s [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic      [SQR_W-1:0]  src_rad;
    logic      [REM_W-1:0]  src_rem;
    logic      [ROOT_W-1:0] src_root;
    rci_side_t              src_side;
    logic      [REM_W+1:0]  sh;
    logic      [REM_W+1:0]  trial;
    logic                   ge;

    if (i == 0) begin : g_first
      assign src_rad  = rad_in;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = side_in;
    end else begin : g_next
      assign src_rad  = rad_s[i];
      assign src_rem  = rem_s[i];
      assign src_root = root_s[i];
      assign src_side = side_s[i];
    end

    // bring down the next two radicand bits and try root*4+1
    assign sh    = {src_rem, src_rad[SQR_W-1:SQR_W-2]};
    assign trial = (REM_W+2)'({src_root, 2'b01});
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        side_s[i+1].valid <= 1'b0;
      end else if (en) begin
        side_s[i+1].valid <= src_side.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[i+1]        <= {src_rad[SQR_W-3:0], 2'b00};
        rem_s[i+1]        <= ge ? REM_W'(sh - trial) : REM_W'(sh);
        root_s[i+1]       <= {src_root[ROOT_W-2:0], ge};
        side_s[i+1].miss  <= src_side.miss;
        side_s[i+1].nb    <= src_side.nb;
      end
    end
  end

  assign root     = root_s[ROOT_W];
  assign side_out = side_s[ROOT_W];

endmodule

@@ hdl/rci_outbuf.sv @@
// distance stage with saturation, output register and one-word skid register
// depends on rci_pkg; drives the pipeline enable from the skid state
module rci_outbuf (
  input  logic                              clk,
  input  logic                              rst,
  input  logic        [rci_pkg::ROOT_W-1:0] root,
  input  rci_pkg::rci_side_t                side,
  output logic                              en,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic        [rci_pkg::OUT_W-1:0]  m_tdata
);
  import rci_pkg::*;

  logic signed [SUM_W-1:0] near_w, far_w;
  logic [OUT_W-1:0] zd, sd;
  logic zv, sv;
  logic load_out, load_skid;

  assign near_w = SUM_W'(side.nb) - SUM_W'(root);
  assign far_w  = SUM_W'(side.nb) + SUM_W'(root);

  assign en        = !sv;
  assign load_out  = en ? (zv && (!m_tvalid || m_tready)) : m_tready;
  assign load_skid = en && zv && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zv       <= 1'b0;
      m_tvalid <= 1'b0;
      sv       <= 1'b0;
    end else begin
      if (en) begin
        zv <= side.valid;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      sv <= en ? load_skid : !m_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side.miss) begin
        zd <= '0;
      end else begin
        zd <= {{(OUT_W - 2*T_W - 1){1'b0}}, sat_t(far_w), sat_t(near_w), 1'b1};
      end
    end
    if (load_out) begin
      m_tdata <= en ? zd : sd;
    end
    if (load_skid) begin
      sd <= zd;
    end
  end

endmodule

@@ hdl/ray_circle_intersection_core.sv @@
// ray/circle intersection core, top level: stream ports and the three pipeline parts
// depends on rci_pkg, rci_front, rci_isqrt and rci_outbuf
//
// Takes one ray/circle word per clock and returns one result word per clock
// while the skid register is empty, a rate set by the fully pipelined square
// root. Stages: six front (offset, products, dot and c, rounded b, b squared,
// h), 27 square root (one root bit each), distance, output register. A one-word
// skid register behind the output register lets the pipeline keep taking words
// while a result waits; when the skid is occupied the whole pipeline holds.
// Distances are Q17.8, zero on a miss.
module ray_circle_intersection_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // origin_x[23:0], origin_y[47:24], dir_x[63:48], dir_y[79:64],
  // center_x[103:80], center_y[127:104], radius[150:128], zero pad [151]
  input  logic [rci_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // hit[0], near_t[26:1], far_t[52:27], zero pad [55:53]
  output logic [rci_pkg::OUT_W-1:0]   m_tdata
);
  import rci_pkg::*;

  logic               en;
  logic [SQR_W-1:0]   rad;
  logic [ROOT_W-1:0]  root;
  rci_side_t          side_f, side_r;

  assign s_tready = en;

  rci_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .origin_x (s_tdata[23:0]),
    .origin_y (s_tdata[47:24]),
    .dir_x    (s_tdata[63:48]),
    .dir_y    (s_tdata[79:64]),
    .center_x (s_tdata[103:80]),
    .center_y (s_tdata[127:104]),
    .radius   (s_tdata[150:128]),
    .rad      (rad),
    .side     (side_f)
  );

  rci_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad_in   (rad),
    .side_in  (side_f),
    .root     (root),
    .side_out (side_r)
  );

  rci_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .root     (root),
    .side     (side_r),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ hdl/rci_checker.sv @@
// port-level checks on the result stream of the ray/circle core
// depends on rci_pkg; bound to ray_circle_intersection_core below
module rci_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [rci_pkg::OUT_W-1:0]  m_tdata
);
  import rci_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // input is held off only while a result word waits
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input held off with no result word waiting");

  // a miss carries zero distances and zero pad
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
    else $error("miss word with nonzero distances");

  // a hit has entry no later than exit, pad clear
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      $signed(m_tdata[T_W:1]) <= $signed(m_tdata[2*T_W:T_W+1])
      && m_tdata[OUT_W-1:2*T_W+1] == '0)
    else $error("hit word with near after far");

endmodule

bind ray_circle_intersection_core rci_checker u_rci_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
